// ----- rtl/fps_pkg.sv -----
// Shared types and constants of the frame playback sequencer.
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int FRAME_BITS = 24;
  localparam int STEP_BITS  = 8;
  localparam int LEN_BITS   = FRAME_BITS + 1;
  localparam int CNT_BITS   = $clog2(FRAME_BITS);
  localparam int MODE_BITS  = 2;
  localparam int IDX_BITS   = 3;

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_FIRST  = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_LAST   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_STRIDE = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_MODE   = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_DIR    = 3'd4;

  // Play modes; the remaining codes behave as ping-pong.
  localparam logic [MODE_BITS-1:0] MODE_ONCE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_LOOP = 2'd1;

  // Item functions.
  localparam logic FUNC_ADVANCE = 1'b0;
  localparam logic FUNC_SEEK    = 1'b1;

  typedef enum logic [2:0] {
    S_RB_START,
    S_RB_WAIT,
    S_IDLE,
    S_DECODE,
    S_STEP,
    S_SK_WAIT,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic rb_start;   // start the length division
    logic rb_load;    // load playback state from the length quotient
    logic item_load;  // capture the accepted item
    logic sk_start;   // start the seek division and range check
    logic sk_load;    // apply the seek result
    logic step_en;    // perform one single step
    logic mul_en;     // register position times stride
    logic out_load;   // fill the output register
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;     // a register write is taken this cycle
    logic cfg_bad;    // stride zero or first above last
    logic div_busy;   // divider still iterating
    logic item_func;  // function of the captured item
    logic step_done;  // advance has made all its steps or play stopped
    logic out_busy;   // result held and stalled
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/frame_playback_sequencer.sv -----
// Top level of the frame playback sequencer: controller, datapath and checks.
//
//   Channel  Direction  Handshake             Payload
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//   in       in         in_valid/in_stall     func, step_count, seek_frame
//   out      out        out_valid/out_stall   current_frame ... config_error
//
// An advance makes one single step per cycle until its step count is reached or play
// has stopped; a seek waits for the divider to finish.
// The next item can be taken once the result is loaded and the controller is idle again.
// After reset and after each register write in_stall stays high while the length is
// divided out. cfg_ready is always high.
// A new item is accepted while a result waits and finishes once that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module frame_playback_sequencer (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [fps_pkg::IDX_BITS-1:0]         cfg_index,
  input  wire  [fps_pkg::FRAME_BITS-1:0]       cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  func,
  input  wire  [fps_pkg::STEP_BITS-1:0]        step_count,
  input  wire  [fps_pkg::FRAME_BITS-1:0]       seek_frame,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [fps_pkg::FRAME_BITS-1:0]       current_frame,
  output logic [fps_pkg::FRAME_BITS-1:0]       current_position,
  output logic [fps_pkg::LEN_BITS-1:0]         sequence_length,
  output logic                                 moving_reverse,
  output logic                                 is_playing,
  output logic [fps_pkg::STEP_BITS-1:0]        boundary_count,
  output logic [fps_pkg::STEP_BITS-1:0]        moves_made,
  output logic                                 seek_error,
  output logic                                 config_error
);
  import fps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  fps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fps_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .func             (func),
    .step_count       (step_count),
    .seek_frame       (seek_frame),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .current_frame    (current_frame),
    .current_position (current_position),
    .sequence_length  (sequence_length),
    .moving_reverse   (moving_reverse),
    .is_playing       (is_playing),
    .boundary_count   (boundary_count),
    .moves_made       (moves_made),
    .seek_error       (seek_error),
    .config_error     (config_error)
  );

  // The length is rebuilt after reset before any item is taken.
  a_stall_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted while the length is being rebuilt");

  // An accepted item keeps the input stalled until its result is built.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while one is in flight");

  // A good configuration always reports a position inside the sequence.
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !config_error) |-> ({1'b0, current_position} < sequence_length))
    else $error("position outside the sequence");

  // A configuration error result carries no other information.
  a_cfg_err_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && config_error) |->
      (current_frame == '0) && (sequence_length == '0) && !is_playing &&
      (moves_made == '0) && !seek_error)
    else $error("configuration error result has nonzero fields");

endmodule

`default_nettype wire

// ----- rtl/fps_ctrl.sv -----
// Controller state machine of the frame playback sequencer.
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire fps_pkg::stat_t stat,
  output fps_pkg::cmd_t       cmd
);
  import fps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RB_START;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    // A register write in the same cycle holds the item back until the rebuild is done.
    in_stall   = (state != S_IDLE) || stat.cfg_wr;
    unique case (state)
      S_RB_START: begin
        cmd.rb_start = 1'b1;
        state_next   = S_RB_WAIT;
      end
      S_RB_WAIT: begin
        if (!stat.div_busy) begin
          cmd.rb_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !stat.cfg_wr) begin
          cmd.item_load = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.cfg_bad) begin
          state_next = S_MUL;
        end else if (stat.item_func == FUNC_SEEK) begin
          cmd.sk_start = 1'b1;
          state_next   = S_SK_WAIT;
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.step_done) begin
          state_next = S_MUL;
        end else begin
          cmd.step_en = 1'b1;
        end
      end
      S_SK_WAIT: begin
        if (!stat.div_busy) begin
          cmd.sk_load = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_RB_START;
      end
    endcase
    // Any register write rebuilds the playback state.
    if (stat.cfg_wr) begin
      state_next = S_RB_START;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fps_dp.sv -----
// Datapath of the frame playback sequencer: registers, divider, stepper, output.
`timescale 1ns / 1ps
`default_nettype none

module fps_dp (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  input  wire  [fps_pkg::IDX_BITS-1:0]         cfg_index,
  input  wire  [fps_pkg::FRAME_BITS-1:0]       cfg_data,
  input  wire                                  func,
  input  wire  [fps_pkg::STEP_BITS-1:0]        step_count,
  input  wire  [fps_pkg::FRAME_BITS-1:0]       seek_frame,
  input  wire  fps_pkg::cmd_t                  cmd,
  output fps_pkg::stat_t                       stat,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [fps_pkg::FRAME_BITS-1:0]       current_frame,
  output logic [fps_pkg::FRAME_BITS-1:0]       current_position,
  output logic [fps_pkg::LEN_BITS-1:0]         sequence_length,
  output logic                                 moving_reverse,
  output logic                                 is_playing,
  output logic [fps_pkg::STEP_BITS-1:0]        boundary_count,
  output logic [fps_pkg::STEP_BITS-1:0]        moves_made,
  output logic                                 seek_error,
  output logic                                 config_error
);
  import fps_pkg::*;

  // Configuration registers
  logic [FRAME_BITS-1:0] first_frame;
  logic [FRAME_BITS-1:0] last_frame;
  logic [FRAME_BITS-1:0] frame_stride;
  logic [MODE_BITS-1:0]  play_mode;
  logic                  start_direction;

  // Playback state
  logic [FRAME_BITS-1:0] position;
  logic [LEN_BITS-1:0]   seq_length;
  logic                  reverse_dir;
  logic                  playing;

  // Item and per-item counters
  logic                  item_func;
  logic [STEP_BITS-1:0]  item_steps;
  logic [FRAME_BITS-1:0] item_seek;
  logic [STEP_BITS-1:0]  step_idx;
  logic [STEP_BITS-1:0]  bounds;
  logic [STEP_BITS-1:0]  moves;
  logic                  serr;
  logic [FRAME_BITS-1:0] product;

  // Divider
  logic                  div_busy;
  logic [CNT_BITS-1:0]   div_cnt;
  logic [FRAME_BITS-1:0] div_rem;
  logic [FRAME_BITS-1:0] div_quo;
  logic [FRAME_BITS-1:0] div_den;
  logic [LEN_BITS-1:0]   rem_sh;
  logic [LEN_BITS-1:0]   rem_sub;
  logic                  rem_ge;

  logic                  cfg_wr;
  logic                  cfg_bad;
  logic                  is_once;
  logic                  is_loop;
  logic [LEN_BITS-1:0]   pos_inc;
  logic [LEN_BITS-1:0]   seq_m1;
  logic [FRAME_BITS-1:0] mul_full;

  assign cfg_wr  = cfg_valid && (cfg_index <= REG_DIR);
  assign cfg_bad = (frame_stride == '0) || (first_frame > last_frame);
  assign is_once = (play_mode == MODE_ONCE);
  assign is_loop = (play_mode == MODE_LOOP);
  assign pos_inc = {1'b0, position} + LEN_BITS'(1);
  assign seq_m1  = seq_length - LEN_BITS'(1);

  assign rem_sh  = {div_rem, div_quo[FRAME_BITS-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_den});
  assign rem_sub = rem_sh - {1'b0, div_den};

  // Only the low frame bits of the product are kept.
  assign mul_full = position * frame_stride;

  always_comb begin
    stat.cfg_wr    = cfg_wr;
    stat.cfg_bad   = cfg_bad;
    stat.div_busy  = div_busy;
    stat.item_func = item_func;
    stat.step_done = (step_idx == item_steps) || !playing;
    stat.out_busy  = out_valid && out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame     <= '0;
      last_frame      <= '0;
      frame_stride    <= FRAME_BITS'(1);
      play_mode       <= MODE_ONCE;
      start_direction <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST:  first_frame     <= cfg_data;
        REG_LAST:   last_frame      <= cfg_data;
        REG_STRIDE: frame_stride    <= cfg_data;
        REG_MODE:   play_mode       <= cfg_data[MODE_BITS-1:0];
        REG_DIR:    start_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.rb_start || cmd.sk_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && (div_cnt == CNT_BITS'(FRAME_BITS - 1))) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rb_start || cmd.sk_start) begin
      div_cnt <= '0;
      div_rem <= '0;
      div_den <= frame_stride;
      div_quo <= cmd.rb_start ? (last_frame - first_frame) : (item_seek - first_frame);
    end else if (div_busy) begin
      div_cnt <= div_cnt + CNT_BITS'(1);
      div_rem <= rem_ge ? rem_sub[FRAME_BITS-1:0] : rem_sh[FRAME_BITS-1:0];
      div_quo <= {div_quo[FRAME_BITS-2:0], rem_ge};
    end
  end

  // Playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      seq_length  <= '0;
      reverse_dir <= 1'b0;
      playing     <= 1'b0;
    end else if (cmd.rb_load) begin
      if (cfg_bad) begin
        position    <= '0;
        seq_length  <= '0;
        reverse_dir <= 1'b0;
        playing     <= 1'b0;
      end else begin
        seq_length  <= {1'b0, div_quo} + LEN_BITS'(1);
        position    <= start_direction ? div_quo : '0;
        reverse_dir <= start_direction;
        playing     <= 1'b1;
      end
    end else if (cmd.sk_load) begin
      if (!serr && (div_rem == '0)) begin
        position <= div_quo;
      end
    end else if (cmd.step_en) begin
      if (seq_length == LEN_BITS'(1)) begin
        if (is_once) begin
          playing <= 1'b0;
        end
      end else if (!reverse_dir) begin
        if (pos_inc < seq_length) begin
          position <= pos_inc[FRAME_BITS-1:0];
        end else if (is_once) begin
          playing <= 1'b0;
        end else if (is_loop) begin
          position <= '0;
        end else begin
          reverse_dir <= 1'b1;
          position    <= position - FRAME_BITS'(1);
        end
      end else begin
        if (position != '0) begin
          position <= position - FRAME_BITS'(1);
        end else if (is_once) begin
          playing <= 1'b0;
        end else if (is_loop) begin
          position <= seq_m1[FRAME_BITS-1:0];
        end else begin
          reverse_dir <= 1'b0;
          position    <= pos_inc[FRAME_BITS-1:0];
        end
      end
    end
  end

  // Per-item registers and step counters.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_func  <= func;
      item_steps <= step_count;
      item_seek  <= seek_frame;
      step_idx   <= '0;
      bounds     <= '0;
      moves      <= '0;
      serr       <= 1'b0;
    end else if (cmd.sk_start) begin
      serr <= (item_seek < first_frame) || (item_seek > last_frame);
    end else if (cmd.sk_load) begin
      serr <= serr || (div_rem != '0);
    end else if (cmd.step_en) begin
      step_idx <= step_idx + STEP_BITS'(1);
      // A step that cannot advance inside the sequence hits an end; it stops play
      // only in once mode.
      if ((seq_length == LEN_BITS'(1)) ||
          (!reverse_dir && !(pos_inc < seq_length)) ||
          (reverse_dir && (position == '0))) begin
        bounds <= bounds + STEP_BITS'(1);
        if (!is_once && (seq_length != LEN_BITS'(1))) begin
          moves <= moves + STEP_BITS'(1);
        end
      end else begin
        moves <= moves + STEP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= mul_full;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cfg_bad) begin
        current_frame    <= '0;
        current_position <= '0;
        sequence_length  <= '0;
        moving_reverse   <= 1'b0;
        is_playing       <= 1'b0;
        boundary_count   <= '0;
        moves_made       <= '0;
        seek_error       <= 1'b0;
        config_error     <= 1'b1;
      end else begin
        current_frame    <= first_frame + product;
        current_position <= position;
        sequence_length  <= seq_length;
        moving_reverse   <= reverse_dir;
        is_playing       <= playing;
        boundary_count   <= bounds;
        moves_made       <= moves;
        seek_error       <= serr;
        config_error     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
